@@ rtl/pcodec_pkg.sv @@
package pcodec_pkg;

	// Fixed field width and result slot count
	localparam int unsigned DATA_W = 8;
	localparam int unsigned MAX_RES = 3;

	// Characters with a special role
	localparam logic [DATA_W-1:0] PCT_CHAR   = 8'h25;
	localparam logic [DATA_W-1:0] TILDE_CHAR = 8'h7E;
	localparam logic [DATA_W-1:0] SLASH_CHAR = 8'h2F;
	localparam logic [DATA_W-1:0] DASH_CHAR  = 8'h2D;
	localparam logic [DATA_W-1:0] DOT_CHAR   = 8'h2E;
	localparam logic [DATA_W-1:0] UNDER_CHAR = 8'h5F;
	localparam logic [3:0]        NIBBLE_MASK = 4'hF;

	// Held-sequence codes of the decoder
	localparam logic [1:0] HELD_NONE  = 2'd0;
	localparam logic [1:0] HELD_PCT   = 2'd1;
	localparam logic [1:0] HELD_DIGIT = 2'd2;

	// Register indexes
	localparam logic REG_MODE = 1'b0;

	// Mode codes
	localparam logic MODE_DECODE = 1'b0;
	localparam logic MODE_ENCODE = 1'b1;

	// Results of one item, slot 0 goes out first
	typedef struct packed {
		logic [1:0]                    count;
		logic [MAX_RES-1:0][DATA_W-1:0] data;
		logic [MAX_RES-1:0]            last;
	} res_t;

	// Decoded hex digit
	typedef struct packed {
		logic       valid;
		logic [3:0] value;
	} hex_t;

	function automatic hex_t hex_decode(input logic [DATA_W-1:0] b);
		hex_t h;
		h.valid = 1'b1;
		h.value = 4'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			h.value = 4'(b - 8'h30);
		end else if (b >= 8'h41 && b <= 8'h46) begin
			h.value = 4'(b - 8'h41 + 8'd10);
		end else if (b >= 8'h61 && b <= 8'h66) begin
			h.value = 4'(b - 8'h61 + 8'd10);
		end else begin
			h.valid = 1'b0;
		end
		return h;
	endfunction

	// Upper-case hex character for a nibble
	function automatic logic [DATA_W-1:0] hex_char(input logic [3:0] n);
		logic [DATA_W-1:0] c;
		if (n < 4'd10) begin
			c = 8'h30 + {4'd0, n};
		end else begin
			c = 8'h41 + {4'd0, n} - 8'd10;
		end
		return c;
	endfunction

	// Bytes that pass the encoder unchanged
	function automatic logic passes_plain(input logic [DATA_W-1:0] b);
		logic p;
		p = (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) ||
			(b >= 8'h30 && b <= 8'h39) || b == DASH_CHAR || b == DOT_CHAR ||
			b == UNDER_CHAR || b == TILDE_CHAR || b == SLASH_CHAR;
		return p;
	endfunction

endpackage

@@ rtl/pcodec_step.sv @@
module pcodec_step import pcodec_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              mode,
	input  logic              clear,
	input  logic              step_en,
	input  logic [DATA_W-1:0] data_s1,
	input  logic              last_s1,
	output res_t              res
);

	logic [1:0]        held_cnt_q;
	logic [DATA_W-1:0] held_dig_q;
	logic [1:0]        nxt_cnt;
	logic [DATA_W-1:0] nxt_dig;
	hex_t              dig_b;
	hex_t              dig_h;
	logic [1:0]        pre;
	logic              fresh;

	assign dig_b = hex_decode(data_s1);
	assign dig_h = hex_decode(held_dig_q);

	// Results and next held state for the item in the input register
	always_comb begin
		res     = '0;
		nxt_cnt = held_cnt_q;
		nxt_dig = held_dig_q;
		pre     = 2'd0;
		fresh   = 1'b0;
		if (mode == MODE_ENCODE) begin
			if (passes_plain(data_s1)) begin
				res.count   = 2'd1;
				res.data[0] = data_s1;
				res.last[0] = last_s1;
			end else begin
				res.count   = 2'd3;
				res.data[0] = PCT_CHAR;
				res.data[1] = hex_char(data_s1[7:4]);
				res.data[2] = hex_char(data_s1[3:0] & NIBBLE_MASK);
				res.last[2] = last_s1;
			end
		end else begin
			fresh = 1'b1;
			case (held_cnt_q)
				HELD_PCT: begin
					if (dig_b.valid && !last_s1) begin
						nxt_cnt = HELD_DIGIT;
						nxt_dig = data_s1;
						fresh   = 1'b0;
					end else begin
						pre         = 2'd1;
						res.data[0] = PCT_CHAR;
					end
				end
				HELD_DIGIT: begin
					if (dig_h.valid && dig_b.valid) begin
						nxt_cnt     = HELD_NONE;
						res.count   = 2'd1;
						res.data[0] = {dig_h.value, dig_b.value};
						res.last[0] = last_s1;
						fresh       = 1'b0;
					end else begin
						pre         = 2'd2;
						res.data[0] = PCT_CHAR;
						res.data[1] = held_dig_q;
					end
				end
				default: begin
					pre = 2'd0;
				end
			endcase
			// the new byte scanned with nothing held
			if (fresh) begin
				if (data_s1 == PCT_CHAR && !last_s1) begin
					nxt_cnt   = HELD_PCT;
					res.count = pre;
				end else begin
					nxt_cnt       = HELD_NONE;
					res.data[pre] = data_s1;
					res.last[pre] = last_s1;
					res.count     = pre + 2'd1;
				end
			end
		end
	end

	// Held sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cnt_q <= HELD_NONE;
			held_dig_q <= '0;
		end else if (clear) begin
			held_cnt_q <= HELD_NONE;
			held_dig_q <= '0;
		end else if (step_en) begin
			held_cnt_q <= nxt_cnt;
			held_dig_q <= nxt_dig;
		end
	end

endmodule

@@ rtl/pcodec_obuf.sv @@
module pcodec_obuf import pcodec_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  res_t              res,
	output logic              can_load,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DATA_W-1:0] m_tdata,   // out_byte[7:0]
	output logic              m_tlast    // out_last
);

	logic [1:0]                     cnt_q;
	logic [1:0]                     rd_q;
	logic [MAX_RES-1:0][DATA_W-1:0] data_q;
	logic [MAX_RES-1:0]             last_q;
	logic                           xfer;

	assign m_tvalid = (cnt_q != 2'd0);
	assign m_tdata  = data_q[rd_q];
	assign m_tlast  = last_q[rd_q];
	assign xfer     = m_tvalid && m_tready;
	// free now, or free once the one remaining result is taken
	assign can_load = (cnt_q == 2'd0) || (cnt_q == 2'd1 && m_tready);

	// Count and read pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			rd_q  <= 2'd0;
		end else if (load) begin
			cnt_q <= res.count;
			rd_q  <= 2'd0;
		end else if (xfer) begin
			cnt_q <= cnt_q - 2'd1;
			rd_q  <= rd_q + 2'd1;
		end
	end

	// Result slots
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= res.data;
			last_q <= res.last;
		end
	end

endmodule

@@ rtl/percent_codec.sv @@
// percent_codec: URL percent encoder / decoder, one byte per transfer.
// Input stream s_*: s_tdata carries the byte, s_tlast marks the last byte of
// a string. Output stream m_*: one coded byte per transfer, m_tlast marks the
// last output byte of the string. Register mode at address 0 of the APB port
// (bit 0: 0 decode, 1 encode); writing it drops any partly held '%' sequence.
// The results of an item pass through the input register, then the result
// buffer. An item gives 0 to 3 results (three for an escaped encoded byte);
// the three-slot result buffer drains one byte per cycle over the output
// port while m_tready is high, and takes the next item's results as its
// last one is taken. Items that give one result or none flow at one per
// cycle while the receiver is ready.
// Reset clears mode to decode, empties the held sequence and both registers.
// When the receiver stalls, the buffer holds its results and the input
// register keeps one item; s_tready drops once both are occupied, and
// nothing is lost or repeated.
module percent_codec import pcodec_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// configuration
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	// input stream
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [DATA_W-1:0] s_tdata,   // in_byte[7:0]
	input  logic              s_tlast,   // in_last
	// output stream
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DATA_W-1:0] m_tdata,   // out_byte[7:0]
	output logic              m_tlast    // out_last
);

	logic              mode_q;
	logic              valid_s1;
	logic [DATA_W-1:0] data_s1;
	logic              last_s1;
	logic              cfg_wr;
	logic              can_load;
	logic              consume;
	res_t              res;

	// APB register access
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_MODE);
	assign prdata = (paddr[2] == REG_MODE) ? {31'd0, mode_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_DECODE;
		end else if (cfg_wr) begin
			mode_q <= pwdata[0];
		end
	end

	// Input register
	assign consume  = valid_s1 && can_load;
	assign s_tready = !valid_s1 || can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			data_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	pcodec_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.mode    (mode_q),
		.clear   (cfg_wr),
		.step_en (consume),
		.data_s1 (data_s1),
		.last_s1 (last_s1),
		.res     (res)
	);

	pcodec_obuf u_obuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (consume),
		.res      (res),
		.can_load (can_load),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

@@ tb/sv/tb_percent_codec.sv @@
`timescale 1ns / 100ps

module tb_percent_codec;
	import pcodec_pkg::*;

	localparam logic [2:0] MODE_ADDR  = 3'(REG_MODE) << 2;
	// first register slot past the mode register, nothing mapped there
	localparam logic [2:0] SPARE_ADDR = 3'd4;
	localparam int DRAIN_LIMIT   = 20000;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 150;
	localparam int PHASE_ITEMS   = 40;

	typedef struct packed {
		logic [DATA_W-1:0] data;
		logic              last;
	} text_byte_t;

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              psel     = 1'b0;
	logic              penable  = 1'b0;
	logic              pwrite   = 1'b0;
	logic [2:0]        paddr    = '0;
	logic [31:0]       pwdata   = '0;
	logic [31:0]       prdata;
	logic              pready;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [DATA_W-1:0] s_tdata  = '0;   // in_byte[7:0]
	logic              s_tlast  = 1'b0; // in_last
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [DATA_W-1:0] m_tdata;         // out_byte[7:0]
	logic              m_tlast;         // out_last

	// stimulus side
	text_byte_t send_q[$];
	int         queued_cnt   = 0;
	int         accepted_cnt = 0;
	int         send_idle_pct  = 0;
	int         recv_stall_pct = 0;
	logic       rx_hold = 1'b0;

	// coder model state and the bytes it expects on the output
	text_byte_t coded_q[$];
	logic       cur_mode   = MODE_DECODE;
	logic [1:0] held_count = HELD_NONE;
	logic [7:0] held_digit = '0;
	string      hex_upper  = "0123456789ABCDEF";
	int         errors     = 0;

	percent_codec i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// coder model
	// ---------------------------------------------------------------
	function automatic bit url_safe(logic [7:0] b);
		if ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || (b >= "0" && b <= "9"))
			return 1'b1;
		case (b)
			DASH_CHAR, DOT_CHAR, UNDER_CHAR, TILDE_CHAR, SLASH_CHAR: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	// value of a hex character, -1 if it is not one
	function automatic int digit_value(logic [7:0] b);
		if (b >= "0" && b <= "9")
			return int'(b) - int'("0");
		if (b >= "A" && b <= "F")
			return int'(b) - int'("A") + 10;
		if (b >= "a" && b <= "f")
			return int'(b) - int'("a") + 10;
		return -1;
	endfunction

	function void emit(logic [7:0] b, logic l);
		text_byte_t t;
		t = '{b, l};
		coded_q.insert(coded_q.size(), t);
	endfunction

	// byte seen with nothing held: a '%' that is not last opens a sequence
	function void scan_plain(logic [7:0] b, logic l);
		if (b == PCT_CHAR && !l) begin
			held_count = HELD_PCT;
		end else begin
			held_count = HELD_NONE;
			emit(b, l);
		end
	endfunction

	function void code_byte(logic [7:0] b, logic l);
		int hi;
		int lo;
		if (cur_mode == MODE_ENCODE) begin
			if (url_safe(b)) begin
				emit(b, l);
			end else begin
				emit(PCT_CHAR, 1'b0);
				emit(hex_upper[b[7:4]], 1'b0);
				emit(hex_upper[b[3:0]], l);
			end
			return;
		end
		case (held_count)
			HELD_PCT: begin
				if (digit_value(b) >= 0 && !l) begin
					held_digit = b;
					held_count = HELD_DIGIT;
				end else begin
					held_count = HELD_NONE;
					emit(PCT_CHAR, 1'b0);
					scan_plain(b, l);
				end
			end
			HELD_DIGIT: begin
				hi = digit_value(held_digit);
				lo = digit_value(b);
				held_count = HELD_NONE;
				if (hi >= 0 && lo >= 0) begin
					emit(8'((hi << 4) | lo), l);
				end else begin
					emit(PCT_CHAR, 1'b0);
					emit(held_digit, 1'b0);
					scan_plain(b, l);
				end
			end
			default: scan_plain(b, l);
		endcase
	endfunction

	function void reg_written(logic [2:0] addr, logic [31:0] val);
		if ((addr >> 2) == REG_MODE) begin
			cur_mode   = val[0];
			held_count = HELD_NONE;
			held_digit = '0;
		end
	endfunction

	// ---------------------------------------------------------------
	// input driver
	// ---------------------------------------------------------------
	always @(posedge clk) begin : drv
		text_byte_t nx;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (send_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				nx = send_q.pop_front();
				s_tdata  <= nx.data;
				s_tlast  <= nx.last;
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// output ready, random stalls plus the long hold-off
	always @(posedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
	end

	// ---------------------------------------------------------------
	// monitor: predict on input transfers, check output transfers
	// ---------------------------------------------------------------
	always @(posedge clk) begin : mon
		text_byte_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				code_byte(s_tdata, s_tlast);
				accepted_cnt++;
			end
			if (m_tvalid && m_tready) begin
				if (coded_q.size() == 0) begin
					$display("%0t: unexpected output byte %h last %b", $time, m_tdata, m_tlast);
					errors++;
				end else begin
					want = coded_q.pop_front();
					if (m_tdata !== want.data) begin
						$display("%0t: out_byte expected %h actual %h", $time, want.data, m_tdata);
						errors++;
					end
					if (m_tlast !== want.last) begin
						$display("%0t: out_last expected %b actual %b", $time, want.last, m_tlast);
						errors++;
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------
	function void push_item(logic [7:0] b, logic l);
		text_byte_t t;
		t = '{b, l};
		send_q.insert(send_q.size(), t);
		queued_cnt++;
	endfunction

	function void queue_text(string s, bit last_at_end);
		for (int i = 0; i < s.len(); i++)
			push_item(s[i], last_at_end && (i == s.len() - 1));
	endfunction

	function automatic logic [7:0] rand_hex_char();
		int n;
		n = $urandom_range(15);
		if (n < 10)
			return 8'(int'("0") + n);
		return 8'(($urandom_range(1) ? int'("A") : int'("a")) + n - 10);
	endfunction

	function automatic logic [7:0] rand_safe_char();
		string punct;
		punct = "-._~/";
		case ($urandom_range(3))
			0: return 8'(int'("a") + $urandom_range(25));
			1: return 8'(int'("A") + $urandom_range(25));
			2: return 8'(int'("0") + $urandom_range(9));
			default: return punct[$urandom_range(4)];
		endcase
	endfunction

	// one string for the decoder: mostly plain bytes and good escapes,
	// some broken escapes, last set on its final byte
	function automatic void queue_url_string();
		logic [7:0] txt[$];
		int pieces;
		int pick;
		pieces = $urandom_range(1, 5);
		for (int p = 0; p < pieces; p++) begin
			pick = $urandom_range(99);
			if (pick < 50) begin
				txt.insert(txt.size(),
					$urandom_range(1) ? rand_safe_char() : 8'($urandom_range(255)));
			end else if (pick < 85) begin
				txt.insert(txt.size(), PCT_CHAR);
				txt.insert(txt.size(), rand_hex_char());
				txt.insert(txt.size(), rand_hex_char());
			end else begin
				txt.insert(txt.size(), PCT_CHAR);
				txt.insert(txt.size(),
					$urandom_range(1) ? rand_hex_char() : 8'($urandom_range(255)));
				if ($urandom_range(1))
					txt.insert(txt.size(), 8'($urandom_range(255)));
			end
		end
		foreach (txt[i])
			push_item(txt[i], i == txt.size() - 1);
	endfunction

	function void fill_random(int n);
		int start;
		start = queued_cnt;
		while (queued_cnt - start < n) begin
			if (cur_mode == MODE_ENCODE)
				push_item($urandom_range(1) ? 8'($urandom_range(255)) : rand_safe_char(),
					$urandom_range(7) == 0);
			else
				queue_url_string();
		end
	endfunction

	task automatic cfg_write(logic [2:0] addr, logic [31:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		reg_written(addr, val);
		if (addr == MODE_ADDR) begin
			// read it back
			penable <= 1'b0;
			pwrite  <= 1'b0;
			@(posedge clk);
			penable <= 1'b1;
			@(posedge clk);
			if (prdata[0] !== cur_mode) begin
				$display("%0t: mode readback expected %b actual %b", $time, cur_mode, prdata[0]);
				errors++;
			end
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// wait for every queued byte to be taken and every expected byte to arrive
	task automatic wait_drained();
		int n;
		n = 0;
		while ((accepted_cnt != queued_cnt || coded_q.size() != 0) && n < DRAIN_LIMIT) begin
			@(posedge clk);
			n++;
		end
		if (n == DRAIN_LIMIT) begin
			$display("%0t: %0d expected byte(s) never arrived, %0d input(s) not taken",
				$time, coded_q.size(), queued_cnt - accepted_cnt);
			errors++;
			coded_q.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// ---------------------------------------------------------------
	// test sequence
	// ---------------------------------------------------------------
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// encoder: pass-through set, escapes, extremes
		cfg_write(MODE_ADDR, 32'(MODE_ENCODE));
		queue_text("azAZ09-._~/", 1'b0);
		push_item(8'h00, 1'b0);
		push_item(8'hFF, 1'b1);
		queue_text("% ", 1'b1);
		wait_drained();

		// decoder: good escapes in both cases, bad first and second digit,
		// cut-off sequences, literal bytes
		cfg_write(MODE_ADDR, 32'(MODE_DECODE));
		queue_text("%41%6a", 1'b0);
		queue_text("%%41", 1'b0);
		queue_text("%4z", 1'b0);
		push_item(8'h00, 1'b0);
		push_item(8'hFF, 1'b1);
		queue_text("%", 1'b1);
		queue_text("%x", 1'b1);
		queue_text("%4", 1'b1);
		queue_text("%", 1'b0);
		wait_drained();
		// write to an unmapped slot leaves the held '%' in place
		cfg_write(SPARE_ADDR, 32'(MODE_ENCODE));
		queue_text("41", 1'b1);
		queue_text("%a", 1'b0);
		wait_drained();

		// random phases; each mode write also drops a held partial escape
		for (int ph = 0; ph < 8; ph++) begin
			case (ph / 2)
				0: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
				1: begin send_idle_pct <= 58; recv_stall_pct <= 0;  end
				2: begin send_idle_pct <= 0;  recv_stall_pct <= 58; end
				default: begin send_idle_pct <= 31; recv_stall_pct <= 31; end
			endcase
			cfg_write(MODE_ADDR, 32'((ph % 2) ? MODE_DECODE : MODE_ENCODE));
			if (ph == 0) begin
				// receiver holds off while the sender keeps offering
				fork
					begin
						rx_hold <= 1'b1;
						repeat (HOLD_CYCLES) @(posedge clk);
						rx_hold <= 1'b0;
					end
				join_none
			end
			fill_random(PHASE_ITEMS);
			wait_drained();
		end

		if (errors == 0)
			$display("percent_codec test passed");
		else
			$display("percent_codec test failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("percent_codec test failed");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/pcodec_pkg.sv
rtl/pcodec_step.sv
rtl/pcodec_obuf.sv
rtl/percent_codec.sv
tb/sv/tb_percent_codec.sv
